FILE: src/rqp_pkg.sv
// Shared constants, payload types and gamma threshold table for the raw quad preview pipeline.
package rqp_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_FRAC_BITS = 12;

   localparam int IN_BITS    = 16;
   localparam int GAIN_BITS  = 16;
   localparam int COEF_BITS  = 16;
   localparam int CHAN_BITS  = SAMPLE_BITS + GAIN_BITS - COEF_FRAC_BITS;
   localparam int PROD_BITS  = COEF_BITS + CHAN_BITS + 1;
   localparam int SUM_BITS   = PROD_BITS + 2;
   localparam int QUOT_BITS  = SUM_BITS - 1 - COEF_FRAC_BITS;
   localparam int NUM_CHAN   = 4;
   localparam int NUM_COLOR  = 3;

   localparam int GAMMA_BITS  = 8;
   localparam int GAMMA_DEPTH = 1 << GAMMA_BITS;
   localparam int GAMMA_SHIFT = 88 - 5 * SAMPLE_BITS;
   localparam int BIG_BITS    = 96;

   // products, clamp, then one stage per gamma output bit
   localparam int COLOR_LATENCY = 2 + GAMMA_BITS;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
   localparam logic [GAIN_BITS-1:0]   UNITY      = GAIN_BITS'(1) << COEF_FRAC_BITS;

   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WB_GAINS    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_RED     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_GREEN   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_BLUE    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CFA_PATTERN = 3'd4;

   localparam logic [7:0] CFA_RGGB = 8'hB4;

   typedef struct packed {
      logic [IN_BITS-1:0] sample_top_left;
      logic [IN_BITS-1:0] sample_top_right;
      logic [IN_BITS-1:0] sample_bottom_left;
      logic [IN_BITS-1:0] sample_bottom_right;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   typedef logic [SAMPLE_BITS:0] gthr_type;
   typedef gthr_type gthr_table_type [GAMMA_DEPTH];

   // Smallest sample level at which each gamma code is reached:
   // min i with i^5 * 2^GAMMA_SHIFT >= v^11.
   function automatic gthr_table_type gamma_thr_table();
      gthr_table_type t;
      logic [BIG_BITS-1:0] lhs;
      logic [BIG_BITS-1:0] rhs;
      logic [SAMPLE_BITS+1:0] lo;
      logic [SAMPLE_BITS+1:0] hi;
      logic [SAMPLE_BITS+1:0] mid;
      for (int v = 0; v < GAMMA_DEPTH; v++) begin
         lhs = BIG_BITS'(1);
         for (int k = 0; k < 11; k++) begin
            lhs = lhs * BIG_BITS'(v);
         end
         lo = '0;
         hi = (SAMPLE_BITS+2)'(1) << SAMPLE_BITS;
         for (int s = 0; s < SAMPLE_BITS + 2; s++) begin
            if (lo < hi) begin
               mid = (lo + hi) >> 1;
               rhs = BIG_BITS'(1);
               for (int k = 0; k < 5; k++) begin
                  rhs = rhs * BIG_BITS'(mid);
               end
               rhs = rhs << GAMMA_SHIFT;
               if (rhs >= lhs) begin
                  hi = mid;
               end else begin
                  lo = mid + 1'b1;
               end
            end
         end
         t[v] = lo[SAMPLE_BITS:0];
      end
      return t;
   endfunction

   localparam gthr_table_type GAMMA_THR = gamma_thr_table();

endpackage

FILE: src/rqp_gain_lane.sv
// One white-balance lane: scales a routed channel by its u4.12 gain.
module rqp_gain_lane
   import rqp_pkg::*;
(
   input  logic                   clock,
   input  logic                   en,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [GAIN_BITS-1:0]   gain,
   output logic [CHAN_BITS-1:0]   scaled
);

   logic [SAMPLE_BITS+GAIN_BITS-1:0] prod;
   logic [CHAN_BITS-1:0]             scaled_in;
   logic [CHAN_BITS-1:0]             scaled_ff;

   assign prod      = (SAMPLE_BITS+GAIN_BITS)'(sample) * (SAMPLE_BITS+GAIN_BITS)'(gain);
   assign scaled_in = prod[SAMPLE_BITS+GAIN_BITS-1:COEF_FRAC_BITS];

   always_ff @(posedge clock) begin
      if (en) begin
         scaled_ff <= scaled_in;
      end
   end

   assign scaled = scaled_ff;

endmodule

FILE: src/rqp_color_lane.sv
// One output color lane: matrix row, clamp, and a bit-per-stage gamma search.
module rqp_color_lane
   import rqp_pkg::*;
(
   input  logic                               clock,
   input  logic                               en,
   input  logic [NUM_COLOR-1:0][CHAN_BITS-1:0] chan,
   input  logic [NUM_COLOR*COEF_BITS-1:0]     row,
   output logic [GAMMA_BITS-1:0]              level
);

   logic signed [PROD_BITS-1:0] prod_in [NUM_COLOR];
   logic signed [PROD_BITS-1:0] prod_ff [NUM_COLOR];
   logic signed [SUM_BITS-1:0]  sum;
   logic [QUOT_BITS-1:0]        quot;
   logic [SAMPLE_BITS-1:0]      idx_in;
   logic [SAMPLE_BITS-1:0]      idx_ff [GAMMA_BITS];
   logic [GAMMA_BITS-1:0]       lvl_in [GAMMA_BITS];
   logic [GAMMA_BITS-1:0]       lvl_ff [GAMMA_BITS];

   always_comb begin
      for (int c = 0; c < NUM_COLOR; c++) begin
         prod_in[c] = PROD_BITS'($signed(row[COEF_BITS*c +: COEF_BITS]))
                    * PROD_BITS'($signed({1'b0, chan[c]}));
      end
   end

   assign sum  = SUM_BITS'(prod_ff[0]) + SUM_BITS'(prod_ff[1]) + SUM_BITS'(prod_ff[2]);
   assign quot = sum[SUM_BITS-2:COEF_FRAC_BITS];

   always_comb begin
      if (sum[SUM_BITS-1]) begin
         idx_in = '0;
      end else if (quot > QUOT_BITS'(SAMPLE_MAX)) begin
         idx_in = SAMPLE_MAX;
      end else begin
         idx_in = quot[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= prod_in;
         idx_ff[0] <= idx_in;
      end
   end

   // Stage k decides output bit GAMMA_BITS-1-k by one threshold lookup.
   for (genvar k = 0; k < GAMMA_BITS; k++) begin : g_step
      logic [GAMMA_BITS-1:0] base;
      logic [GAMMA_BITS-1:0] cand;

      if (k == 0) begin : g_first
         assign base = '0;
      end else begin : g_next
         assign base = lvl_ff[k-1];
      end

      assign cand      = base | (GAMMA_BITS'(1) << (GAMMA_BITS - 1 - k));
      assign lvl_in[k] = (GAMMA_THR[cand] <= {1'b0, idx_ff[k]}) ? cand : base;

      always_ff @(posedge clock) begin
         if (en) begin
            lvl_ff[k] <= lvl_in[k];
         end
      end

      if (k < GAMMA_BITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               idx_ff[k+1] <= idx_ff[k];
            end
         end
      end
   end

   assign level = lvl_ff[GAMMA_BITS-1];

endmodule

FILE: src/raw_quad_preview_pipeline.sv
// Pipeline: a result reaches rsp_valid from its req transfer through routing, gain,
//   green average, matrix products, clamp, 8 gamma search stages and the output register.
// Throughput: one quad per cycle; the whole pipe holds while a result waits under rsp_stall.
// The 8 gamma stages each decide one output bit from the threshold table.
// Reset (synchronous, active high) empties the pipe and loads unity gains, identity
//   matrix and RGGB pattern; csr_ready is always high.
module raw_quad_preview_pipeline
   import rqp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [63:0]               csr_data
);

   localparam int PIPE_DEPTH = 3 + COLOR_LATENCY + 1;
   localparam int ROW_BITS   = NUM_COLOR * COEF_BITS;

   logic                             en;
   logic                             req_accept;
   logic [PIPE_DEPTH-1:0]            vld_in;
   logic [PIPE_DEPTH-1:0]            vld_ff;

   logic [NUM_CHAN*GAIN_BITS-1:0]    gains_in,  gains_ff;
   logic [ROW_BITS-1:0]              row_r_in,  row_r_ff;
   logic [ROW_BITS-1:0]              row_g_in,  row_g_ff;
   logic [ROW_BITS-1:0]              row_b_in,  row_b_ff;
   logic [7:0]                       cfa_in,    cfa_ff;

   logic [IN_BITS-1:0]               raw   [NUM_CHAN];
   logic [SAMPLE_BITS-1:0]           sat   [NUM_CHAN];
   logic [SAMPLE_BITS-1:0]           ch_in [NUM_CHAN];
   logic [SAMPLE_BITS-1:0]           ch_ff [NUM_CHAN];
   logic [CHAN_BITS-1:0]             scaled [NUM_CHAN];
   logic [CHAN_BITS:0]               green_sum;
   logic [NUM_COLOR-1:0][CHAN_BITS-1:0] chan_in, chan_ff;
   logic [GAMMA_BITS-1:0]            level [NUM_COLOR];
   rsp_type                          rsp_in, rsp_ff;

   assign en         = !(rsp_valid && rsp_stall);
   assign req_stall  = !en;
   assign req_accept = req_valid && en;
   assign csr_ready  = 1'b1;

   // configuration registers
   always_comb begin
      gains_in = gains_ff;
      row_r_in = row_r_ff;
      row_g_in = row_g_ff;
      row_b_in = row_b_ff;
      cfa_in   = cfa_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WB_GAINS:    gains_in = csr_data;
            CSR_ROW_RED:     row_r_in = csr_data[ROW_BITS-1:0];
            CSR_ROW_GREEN:   row_g_in = csr_data[ROW_BITS-1:0];
            CSR_ROW_BLUE:    row_b_in = csr_data[ROW_BITS-1:0];
            CSR_CFA_PATTERN: cfa_in   = csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff <= {NUM_CHAN{UNITY}};
         row_r_ff <= ROW_BITS'(UNITY);
         row_g_ff <= ROW_BITS'(UNITY) << COEF_BITS;
         row_b_ff <= ROW_BITS'(UNITY) << (2 * COEF_BITS);
         cfa_ff   <= CFA_RGGB;
      end else begin
         gains_ff <= gains_in;
         row_r_ff <= row_r_in;
         row_g_ff <= row_g_in;
         row_b_ff <= row_b_in;
         cfa_ff   <= cfa_in;
      end
   end

   // valid tracking
   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], req_accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // route samples to channels; later quad positions win on a repeated channel
   assign raw[0] = req_data.sample_top_left;
   assign raw[1] = req_data.sample_top_right;
   assign raw[2] = req_data.sample_bottom_left;
   assign raw[3] = req_data.sample_bottom_right;

   always_comb begin
      for (int p = 0; p < NUM_CHAN; p++) begin
         sat[p] = (raw[p] > IN_BITS'(SAMPLE_MAX)) ? SAMPLE_MAX : raw[p][SAMPLE_BITS-1:0];
      end
      for (int c = 0; c < NUM_CHAN; c++) begin
         ch_in[c] = '0;
         for (int p = 0; p < NUM_CHAN; p++) begin
            if (cfa_ff[2*p +: 2] == 2'(c)) begin
               ch_in[c] = sat[p];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ch_ff <= ch_in;
      end
   end

   for (genvar c = 0; c < NUM_CHAN; c++) begin : g_gain
      rqp_gain_lane u_gain (
         .clock  (clock),
         .en     (en),
         .sample (ch_ff[c]),
         .gain   (gains_ff[GAIN_BITS*c +: GAIN_BITS]),
         .scaled (scaled[c])
      );
   end

   // the two greens are averaged into channel 1
   assign green_sum  = (CHAN_BITS+1)'(scaled[1]) + (CHAN_BITS+1)'(scaled[3]);
   assign chan_in[0] = scaled[0];
   assign chan_in[1] = green_sum[CHAN_BITS:1];
   assign chan_in[2] = scaled[2];

   always_ff @(posedge clock) begin
      if (en) begin
         chan_ff <= chan_in;
      end
   end

   rqp_color_lane u_red (
      .clock (clock),
      .en    (en),
      .chan  (chan_ff),
      .row   (row_r_ff),
      .level (level[0])
   );

   rqp_color_lane u_green (
      .clock (clock),
      .en    (en),
      .chan  (chan_ff),
      .row   (row_g_ff),
      .level (level[1])
   );

   rqp_color_lane u_blue (
      .clock (clock),
      .en    (en),
      .chan  (chan_ff),
      .row   (row_b_ff),
      .level (level[2])
   );

   // merge lane results into the output register
   always_comb begin
      rsp_in.red   = level[0];
      rsp_in.green = level[1];
      rsp_in.blue  = level[2];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff[PIPE_DEPTH-1];
   assign rsp_data  = rsp_ff;

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipe valids moved while output stalled");

   a_handoff: assert property (@(posedge clock) disable iff (reset)
      en && vld_ff[PIPE_DEPTH-2] |=> rsp_valid)
      else $error("last stage item lost on way to output");

   a_cfa_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && csr_index == CSR_CFA_PATTERN |=> cfa_ff == $past(csr_data[7:0]))
      else $error("cfa pattern write not taken");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule
